// ===== hw/rtl/sha256_stream_hasher_unit_assert.svh =====
// Assertion macros for the SHA-256 stream hasher
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH

// checked only outside reset
`define SHS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SHS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/shs_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher
`default_nettype none
package shs_pkg;

   localparam int unsigned QueueDepthDef = 4;

   localparam logic [7:0] PadByte  = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       msg_last;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } core_state_type;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage
`default_nettype wire

// ===== hw/rtl/shs_front.sv =====
// Front end: takes requests, drops empty ones, queues the rest for the core
`default_nettype none
module shs_front #(
   parameter int unsigned Depth = shs_pkg::QueueDepthDef
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_msg_byte,
   input  wire logic              req_byte_valid,
   input  wire logic              req_msg_last,
   output logic                   fe_valid,
   output shs_pkg::item_type      fe_item,
   input  wire logic              fe_pop
);
   import shs_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   item_type        queue_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;

   assign req_ready = (count_ff != CntFull);
   // a request with neither a byte nor a close does nothing, so it is not queued
   assign push      = req_valid && req_ready && (req_byte_valid || req_msg_last);
   assign fe_valid  = (count_ff != '0);
   assign fe_item   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (fe_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !fe_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!push && fe_pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{msg_byte: req_msg_byte, byte_valid: req_byte_valid,
                                  msg_last: req_msg_last};
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/shs_core.sv =====
// Back end: block gathering, padding, 64-round compression and digest output
`default_nettype none
module shs_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fe_valid,
   input  wire shs_pkg::item_type fe_item,
   output logic                   fe_pop,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_digest_word,
   output logic [2:0]             rsp_word_index,
   output logic                   rsp_digest_last
);
   import shs_pkg::*;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   core_state_type state_ff, state_in;

   logic [511:0] window_ff, window_in;   // block bytes, then message schedule
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [63:0]  len_ff, len_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic [2:0]   widx_ff, widx_in;
   logic         last_pend_ff, last_pend_in;
   logic         sent80_ff, sent80_in;
   logic         final_ff, final_in;
   logic [31:0]  work_ff [8];
   logic [31:0]  work_in [8];
   logic [31:0]  chain_ff [8];
   logic [31:0]  chain_in [8];
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_word_ff, rsp_word_in;
   logic [2:0]   rsp_idx_ff, rsp_idx_in;
   logic         rsp_last_ff, rsp_last_in;

   // control outputs
   logic         shift_en;
   logic [7:0]   shift_byte;
   logic         take_byte;
   logic         load_work;
   logic         round_en;
   logic         fold_en;
   logic         out_load;

   // round datapath
   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] s0, s1, big_a, big_e, pick, vote, t_one, t_two;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fe_valid) begin
               if (fe_item.byte_valid && fill_ff == 6'd63) begin
                  state_in = ST_ROUND;
               end else if (fe_item.msg_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == 6'd63) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (sent80_ff) begin
               state_in = final_ff ? ST_OUT : ST_PAD;
            end else begin
               state_in = last_pend_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_load && widx_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      fe_pop     = 1'b0;
      take_byte  = 1'b0;
      shift_en   = 1'b0;
      shift_byte = '0;
      round_en   = 1'b0;
      fold_en    = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            fe_pop     = fe_valid;
            take_byte  = fe_valid && fe_item.byte_valid;
            shift_en   = take_byte;
            shift_byte = fe_item.msg_byte;
         end
         ST_PAD: begin
            shift_en = 1'b1;
            priority if (!sent80_ff) begin
               shift_byte = PadByte;
            end else if (final_ff && fill_ff >= LenStart) begin
               shift_byte = len_ff[63:56];
            end else begin
               shift_byte = '0;
            end
         end
         ST_ROUND: round_en = 1'b1;
         ST_FOLD:  fold_en  = 1'b1;
         ST_OUT:   out_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign load_work = (state_ff != ST_ROUND) && (state_in == ST_ROUND);

   // one round of the compression
   assign w0  = window_ff[511:480];
   assign w1  = window_ff[479:448];
   assign w9  = window_ff[223:192];
   assign w14 = window_ff[63:32];
   assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
   assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
   assign w_new = s1 + w9 + s0 + w0;

   assign big_e = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
   assign pick  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign big_a = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
   assign vote  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]);
   assign t_one = work_ff[7] + big_e + pick + RoundK[rnd_ff] + w0;
   assign t_two = big_a + vote;

   // datapath next values
   always_comb begin
      window_in    = window_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      len_in       = len_ff;
      rnd_in       = rnd_ff;
      widx_in      = widx_ff;
      last_pend_in = last_pend_ff;
      sent80_in    = sent80_ff;
      final_in     = final_ff;
      work_in      = work_ff;
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      if (shift_en) begin
         window_in = {window_ff[503:0], shift_byte};
         fill_in   = fill_ff + 6'd1;
      end
      if (take_byte) begin
         bits_in = bits_ff + 64'd8;
         if (fill_ff == 6'd63) begin
            last_pend_in = fe_item.msg_last;
         end
      end
      if (state_ff == ST_PAD) begin
         if (!sent80_ff) begin
            sent80_in = 1'b1;
            len_in    = bits_ff;
            if (fill_ff < LenStart) begin
               final_in = 1'b1;
            end
         end else if (final_ff && fill_ff >= LenStart) begin
            len_in = {len_ff[55:0], 8'h00};
         end
      end
      if (load_work) begin
         work_in = chain_ff;
         rnd_in  = '0;
      end
      if (round_en) begin
         window_in  = {window_ff[479:0], w_new};
         rnd_in     = rnd_ff + 6'd1;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t_one;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t_one + t_two;
      end
      if (fold_en) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
         last_pend_in = 1'b0;
         // an overflow pad block is followed by the block carrying the length
         if (sent80_ff) begin
            final_in = 1'b1;
         end
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = chain_ff[widx_ff];
         rsp_idx_in   = widx_ff;
         rsp_last_in  = (widx_ff == 3'd7);
         widx_in      = widx_ff + 3'd1;
         if (widx_ff == 3'd7) begin
            chain_in  = InitHash;
            bits_in   = '0;
            sent80_in = 1'b0;
            final_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         rnd_ff       <= '0;
         widx_ff      <= '0;
         last_pend_ff <= 1'b0;
         sent80_ff    <= 1'b0;
         final_ff     <= 1'b0;
         chain_ff     <= InitHash;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         rnd_ff       <= rnd_in;
         widx_ff      <= widx_in;
         last_pend_ff <= last_pend_in;
         sent80_ff    <= sent80_in;
         final_ff     <= final_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      len_ff      <= len_in;
      work_ff     <= work_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_digest_last = rsp_last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// A byte request is queued in the front end and absorbed by the core when the core is idle.
// Each full 64-byte block then holds the core for its 64 rounds and the chain add.
// The core takes no new bytes while its single round unit works on a block.
// Close: padding adds 9..72 bytes in one or two blocks, then 8 words go out, 1 a cycle while rsp_ready allows.
// Reset (synchronous, active high) empties the queue and returns chaining to the IV.
`default_nettype none
module sha256_stream_hasher_unit #(
   parameter int unsigned QueueDepth = shs_pkg::QueueDepthDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_msg_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_digest_last
);
   import shs_pkg::*;

   logic     fe_valid;
   logic     fe_pop;
   item_type fe_item;

   shs_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_msg_byte   (req_msg_byte),
      .req_byte_valid (req_byte_valid),
      .req_msg_last   (req_msg_last),
      .fe_valid       (fe_valid),
      .fe_item        (fe_item),
      .fe_pop         (fe_pop)
   );

   shs_core u_core (
      .clock           (clock),
      .reset           (reset),
      .fe_valid        (fe_valid),
      .fe_item         (fe_item),
      .fe_pop          (fe_pop),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_last (rsp_digest_last)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/shs_checker.sv =====
// Port-level checks for the SHA-256 stream hasher, bound to the top level
`default_nettype none
`include "sha256_stream_hasher_unit_assert.svh"
module shs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_digest_last
);

   `SHS_ASSERT_ALWAYS(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid, "response right after reset")

   `SHS_ASSERT(a_last_on_word7, rsp_valid |-> (rsp_digest_last == (rsp_word_index == 3'd7)), "last flag off word 7")

   `SHS_ASSERT(a_words_back_to_back, (rsp_valid && rsp_ready && !rsp_digest_last) |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1), "digest words not in sequence")

   `SHS_ASSERT(a_rsp_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index)), "stalled response changed")

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (.*);
`default_nettype wire
